### design/pairwise_gravity_force_macros.svh
// Assertion macros for the pairwise gravity force block.
`ifndef PAIRWISE_GRAVITY_FORCE_MACROS_SVH
`define PAIRWISE_GRAVITY_FORCE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PGF_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pairwise_gravity_force: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PGF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pairwise_gravity_force: next-cycle check failed");

`endif

### design/pgf_pkg.sv
// Shared constants for the pairwise gravity force block.
package pgf_pkg;

  localparam int unsigned CoordWidth  = 32;
  localparam int unsigned MassW       = 32;
  localparam int unsigned GravW       = 32;
  localparam int unsigned ForceW      = 48;
  localparam int unsigned DigitW      = 16;
  localparam int unsigned TooCloseExp = 24;
  localparam logic [GravW-1:0] GravReset = 32'h0100_0000;

endpackage

### design/pgf_mul.sv
// Digit-serial multiplier row: one 16-bit digit of b per cell, operands ride along.
module pgf_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32,
  parameter int unsigned TW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  input  logic [TW-1:0]    tag_i,
  output logic             valid_o,
  output logic [AW+BW-1:0] p_o,
  output logic [TW-1:0]    tag_o
);

  localparam int unsigned DW = pgf_pkg::DigitW;
  localparam int unsigned ND = (BW + DW - 1) / DW;
  localparam int unsigned BP = ND * DW;
  localparam int unsigned PW = AW + BW;

  logic          v_q   [ND];
  logic [AW-1:0] a_q   [ND];
  logic [BP-1:0] b_q   [ND];
  logic [PW-1:0] acc_q [ND];
  logic [TW-1:0] tag_q [ND];

  for (genvar k = 0; k < ND; k++) begin : g_cell
    logic             v_in;
    logic [AW-1:0]    a_in;
    logic [BP-1:0]    b_in;
    logic [PW-1:0]    acc_in;
    logic [TW-1:0]    tag_in;
    logic [AW+DW-1:0] pp;

    if (k == 0) begin : g_head
      assign v_in   = valid_i;
      assign a_in   = a_i;
      assign b_in   = BP'(b_i);
      assign acc_in = '0;
      assign tag_in = tag_i;
    end else begin : g_link
      assign v_in   = v_q[k-1];
      assign a_in   = a_q[k-1];
      assign b_in   = b_q[k-1];
      assign acc_in = acc_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    assign pp = a_in * b_in[k*DW +: DW];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      a_q[k]   <= a_in;
      b_q[k]   <= b_in;
      acc_q[k] <= acc_in + (PW'(pp) << (k * DW));
      tag_q[k] <= tag_in;
    end
  end

  assign valid_o = v_q[ND-1];
  assign p_o     = acc_q[ND-1];
  assign tag_o   = tag_q[ND-1];

endmodule

### design/pgf_sqrt.sv
// Integer square root row: one root bit per cell, from the top bit down.
module pgf_sqrt #(
  parameter int unsigned RW = 33,
  parameter int unsigned TW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [2*RW-2:0] value_i,
  input  logic [TW-1:0]   tag_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [TW-1:0]   tag_o
);

  localparam int unsigned VW = 2 * RW - 1;
  localparam int unsigned EW = 2 * RW + 1;

  logic          v_q   [RW];
  logic [VW-1:0] x_q   [RW];
  logic [RW-1:0] r_q   [RW];
  logic [TW-1:0] tag_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_cell
    localparam int unsigned B = RW - 1 - k;
    logic          v_in;
    logic [VW-1:0] x_in;
    logic [RW-1:0] r_in;
    logic [TW-1:0] tag_in;
    logic [EW-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_head
      assign v_in   = valid_i;
      assign x_in   = value_i;
      assign r_in   = '0;
      assign tag_in = tag_i;
    end else begin : g_link
      assign v_in   = v_q[k-1];
      assign x_in   = x_q[k-1];
      assign r_in   = r_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    // (r + 2^B)^2 - r^2
    assign trial = (EW'(r_in) << (B + 1)) + (EW'(1) << (2 * B));
    assign ge    = EW'(x_in) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[k]   <= ge ? VW'(EW'(x_in) - trial) : x_in;
      r_q[k]   <= ge ? (r_in | (RW'(1) << B)) : r_in;
      tag_q[k] <= tag_in;
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = r_q[RW-1];
  assign tag_o   = tag_q[RW-1];

endmodule

### design/pgf_div.sv
// Restoring divider row for two numerators over one divisor, one quotient bit per cell.
module pgf_div #(
  parameter int unsigned NW  = 128,
  parameter int unsigned DNW = 104,
  parameter int unsigned QW  = 48,
  parameter int unsigned TW  = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [NW-1:0]  nx_i,
  input  logic [NW-1:0]  ny_i,
  input  logic [DNW-1:0] den_i,
  input  logic [TW-1:0]  tag_i,
  output logic           valid_o,
  output logic [QW-1:0]  qx_o,
  output logic [QW-1:0]  qy_o,
  output logic [TW-1:0]  tag_o
);

  localparam int unsigned EW = (NW > DNW + QW) ? NW : DNW + QW;

  logic           v_q   [QW];
  logic [EW-1:0]  rx_q  [QW];
  logic [EW-1:0]  ry_q  [QW];
  logic [QW-1:0]  qx_q  [QW];
  logic [QW-1:0]  qy_q  [QW];
  logic [DNW-1:0] den_q [QW];
  logic [TW-1:0]  tag_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_cell
    localparam int unsigned I = QW - 1 - k;
    logic           v_in;
    logic [EW-1:0]  rx_in;
    logic [EW-1:0]  ry_in;
    logic [QW-1:0]  qx_in;
    logic [QW-1:0]  qy_in;
    logic [DNW-1:0] den_in;
    logic [TW-1:0]  tag_in;
    logic [EW-1:0]  dsh;
    logic           gex;
    logic           gey;

    if (k == 0) begin : g_head
      assign v_in   = valid_i;
      assign rx_in  = EW'(nx_i);
      assign ry_in  = EW'(ny_i);
      assign qx_in  = '0;
      assign qy_in  = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_link
      assign v_in   = v_q[k-1];
      assign rx_in  = rx_q[k-1];
      assign ry_in  = ry_q[k-1];
      assign qx_in  = qx_q[k-1];
      assign qy_in  = qy_q[k-1];
      assign den_in = den_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    assign dsh = EW'(den_in) << I;
    assign gex = rx_in >= dsh;
    assign gey = ry_in >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rx_q[k]  <= gex ? (rx_in - dsh) : rx_in;
      ry_q[k]  <= gey ? (ry_in - dsh) : ry_in;
      qx_q[k]  <= gex ? (qx_in | (QW'(1) << I)) : qx_in;
      qy_q[k]  <= gey ? (qy_in | (QW'(1) << I)) : qy_in;
      den_q[k] <= den_in;
      tag_q[k] <= tag_in;
    end
  end

  assign valid_o = v_q[QW-1];
  assign qx_o    = qx_q[QW-1];
  assign qy_o    = qy_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

### design/pairwise_gravity_force.sv
// Top level: pipelined 2D pairwise gravity force, one body pair per cycle.
// Throughput: one pair per cycle, busy_o is never raised.
// The longest rows in the pipeline are the square-root row and the 48-cell divider row.
// Results come out on done_o in accept order; the receiver cannot stall.
// Reset clears all valid bits and loads G = 1.0; in-flight pairs are dropped.
`include "pairwise_gravity_force_macros.svh"

module pairwise_gravity_force #(
  parameter int unsigned COORD_WIDTH = pgf_pkg::CoordWidth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [COORD_WIDTH-1:0]      self_x_i,
  input  logic signed [COORD_WIDTH-1:0]      self_y_i,
  input  logic [pgf_pkg::MassW-1:0]          self_mass_i,
  input  logic signed [COORD_WIDTH-1:0]      other_x_i,
  input  logic signed [COORD_WIDTH-1:0]      other_y_i,
  input  logic [pgf_pkg::MassW-1:0]          other_mass_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pgf_pkg::GravW-1:0]          cfg_data_i,
  output logic                               done_o,
  output logic signed [pgf_pkg::ForceW-1:0]  force_x_o,
  output logic signed [pgf_pkg::ForceW-1:0]  force_y_o,
  output logic                               too_close_o,
  output logic                               saturated_o
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned SQW  = 2 * CW;
  localparam int unsigned D2W  = 2 * CW + 1;
  localparam int unsigned RW   = CW + 1;
  localparam int unsigned MW   = pgf_pkg::MassW;
  localparam int unsigned GW   = pgf_pkg::GravW;
  localparam int unsigned GMW  = GW + MW;
  localparam int unsigned NUMW = GMW + MW;
  localparam int unsigned NPW  = NUMW + CW;
  localparam int unsigned DENW = D2W + RW + 4;
  localparam int unsigned QW   = pgf_pkg::ForceW;
  localparam int unsigned EW   = (NPW > DENW + QW) ? NPW : DENW + QW;

  typedef struct packed {
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    logic          sx;
    logic          sy;
    logic [MW-1:0] m1;
    logic [MW-1:0] m2;
  } base_t;

  typedef struct packed {
    logic [SQW-1:0] ax2;
    base_t          b;
  } sq_t;

  typedef struct packed {
    logic           tc;
    logic [D2W-1:0] d2;
    base_t          b;
  } ct_t;

  typedef struct packed {
    logic [RW-1:0] r;
    ct_t           c;
  } rt_t;

  typedef struct packed {
    logic [NUMW-1:0] num;
    logic [CW-1:0]   ax;
    logic [CW-1:0]   ay;
    logic            sx;
    logic            sy;
    logic            tc;
  } nt_t;

  typedef struct packed {
    logic [DENW-1:0] den;
    nt_t             n;
  } dt_t;

  typedef struct packed {
    logic [NPW-1:0]  nx;
    logic [DENW-1:0] den;
    logic            sx;
    logic            sy;
    logic            tc;
  } xt_t;

  typedef struct packed {
    logic bigx;
    logic bigy;
    logic sx;
    logic sy;
    logic tc;
  } ft_t;

  function automatic logic [QW:0] clip(logic [QW-1:0] q, logic big, logic neg);
    logic [QW-1:0] lim;
    logic [QW-1:0] mag;
    logic          over;
    lim  = neg ? (QW'(1) << (QW - 1)) : ((QW'(1) << (QW - 1)) - QW'(1));
    over = big || (q > lim);
    mag  = over ? lim : q;
    return {over, (neg ? (QW'(0) - mag) : mag)};
  endfunction

  logic [GW-1:0] gravity_q;
  logic          accept;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= pgf_pkg::GravReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      gravity_q <= cfg_data_i;
    end
  end

  // stage A: displacements
  logic          va_q;
  logic [CW:0]   dx_q;
  logic [CW:0]   dy_q;
  logic [MW-1:0] m1_q;
  logic [MW-1:0] m2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= {other_x_i[CW-1], other_x_i} - {self_x_i[CW-1], self_x_i};
    dy_q <= {other_y_i[CW-1], other_y_i} - {self_y_i[CW-1], self_y_i};
    m1_q <= self_mass_i;
    m2_q <= other_mass_i;
  end

  // stage B: magnitudes and signs
  logic  vb_q;
  base_t base_d;
  base_t base_q;

  always_comb begin
    base_d.sx = dx_q[CW];
    base_d.sy = dy_q[CW];
    base_d.ax = dx_q[CW] ? CW'(-dx_q) : CW'(dx_q);
    base_d.ay = dy_q[CW] ? CW'(-dy_q) : CW'(dy_q);
    base_d.m1 = m1_q;
    base_d.m2 = m2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
  end

  // squares
  logic           v1;
  logic [SQW-1:0] ax2;
  base_t          t1;

  pgf_mul #(.AW(CW), .BW(CW), .TW($bits(base_t))) u_sq_x (
    .clk_i, .rst_ni,
    .valid_i(vb_q), .a_i(base_q.ax), .b_i(base_q.ax), .tag_i(base_q),
    .valid_o(v1), .p_o(ax2), .tag_o(t1)
  );

  logic           v2;
  logic [SQW-1:0] ay2;
  sq_t            t2_in;
  sq_t            t2;

  assign t2_in.ax2 = ax2;
  assign t2_in.b   = t1;

  pgf_mul #(.AW(CW), .BW(CW), .TW($bits(sq_t))) u_sq_y (
    .clk_i, .rst_ni,
    .valid_i(v1), .a_i(t1.ay), .b_i(t1.ay), .tag_i(t2_in),
    .valid_o(v2), .p_o(ay2), .tag_o(t2)
  );

  // stage C: squared distance
  logic vc_q;
  ct_t  c_d;
  ct_t  c_q;

  always_comb begin
    c_d.d2 = D2W'(t2.ax2) + D2W'(ay2);
    c_d.tc = ~|c_d.d2[D2W-1:pgf_pkg::TooCloseExp];
    c_d.b  = t2.b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= v2;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
  end

  // distance
  logic          v3;
  logic [RW-1:0] root;
  ct_t           t3;

  pgf_sqrt #(.RW(RW), .TW($bits(ct_t))) u_sqrt (
    .clk_i, .rst_ni,
    .valid_i(vc_q), .value_i(c_q.d2), .tag_i(c_q),
    .valid_o(v3), .root_o(root), .tag_o(t3)
  );

  // G * m1 * m2
  logic           v4;
  logic [GMW-1:0] gm1;
  rt_t            t4_in;
  rt_t            t4;

  assign t4_in.r = root;
  assign t4_in.c = t3;

  pgf_mul #(.AW(GW), .BW(MW), .TW($bits(rt_t))) u_gm1 (
    .clk_i, .rst_ni,
    .valid_i(v3), .a_i(gravity_q), .b_i(t3.b.m1), .tag_i(t4_in),
    .valid_o(v4), .p_o(gm1), .tag_o(t4)
  );

  logic            v5;
  logic [NUMW-1:0] num;
  rt_t             t5;

  pgf_mul #(.AW(GMW), .BW(MW), .TW($bits(rt_t))) u_gm2 (
    .clk_i, .rst_ni,
    .valid_i(v4), .a_i(gm1), .b_i(t4.c.b.m2), .tag_i(t4),
    .valid_o(v5), .p_o(num), .tag_o(t5)
  );

  // D2 * R
  logic              v6;
  logic [D2W+RW-1:0] d2r;
  nt_t               t6_in;
  nt_t               t6;

  always_comb begin
    t6_in.num = num;
    t6_in.ax  = t5.c.b.ax;
    t6_in.ay  = t5.c.b.ay;
    t6_in.sx  = t5.c.b.sx;
    t6_in.sy  = t5.c.b.sy;
    t6_in.tc  = t5.c.tc;
  end

  pgf_mul #(.AW(D2W), .BW(RW), .TW($bits(nt_t))) u_den (
    .clk_i, .rst_ni,
    .valid_i(v5), .a_i(t5.c.d2), .b_i(t5.r), .tag_i(t6_in),
    .valid_o(v6), .p_o(d2r), .tag_o(t6)
  );

  // numerators
  logic           v7;
  logic [NPW-1:0] nx;
  dt_t            t7_in;
  dt_t            t7;

  assign t7_in.den = {d2r, 4'b0000};
  assign t7_in.n   = t6;

  pgf_mul #(.AW(NUMW), .BW(CW), .TW($bits(dt_t))) u_num_x (
    .clk_i, .rst_ni,
    .valid_i(v6), .a_i(t6.num), .b_i(t6.ax), .tag_i(t7_in),
    .valid_o(v7), .p_o(nx), .tag_o(t7)
  );

  logic           v8;
  logic [NPW-1:0] ny;
  xt_t            t8_in;
  xt_t            t8;

  always_comb begin
    t8_in.nx  = nx;
    t8_in.den = t7.den;
    t8_in.sx  = t7.n.sx;
    t8_in.sy  = t7.n.sy;
    t8_in.tc  = t7.n.tc;
  end

  pgf_mul #(.AW(NUMW), .BW(CW), .TW($bits(xt_t))) u_num_y (
    .clk_i, .rst_ni,
    .valid_i(v7), .a_i(t7.n.num), .b_i(t7.n.ay), .tag_i(t8_in),
    .valid_o(v8), .p_o(ny), .tag_o(t8)
  );

  // stage D: quotient overflow check
  logic            vd_q;
  logic [NPW-1:0]  nx_q;
  logic [NPW-1:0]  ny_q;
  logic [DENW-1:0] den_q;
  ft_t             f_d;
  ft_t             f_q;
  logic [EW-1:0]   den_top;

  assign den_top = EW'(t8.den) << QW;

  always_comb begin
    f_d.bigx = EW'(t8.nx) >= den_top;
    f_d.bigy = EW'(ny) >= den_top;
    f_d.sx   = t8.sx;
    f_d.sy   = t8.sy;
    f_d.tc   = t8.tc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else begin
      vd_q <= v8;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q  <= t8.nx;
    ny_q  <= ny;
    den_q <= t8.den;
    f_q   <= f_d;
  end

  // division
  logic          v9;
  logic [QW-1:0] qx;
  logic [QW-1:0] qy;
  ft_t           t9;

  pgf_div #(.NW(NPW), .DNW(DENW), .QW(QW), .TW($bits(ft_t))) u_div (
    .clk_i, .rst_ni,
    .valid_i(vd_q), .nx_i(nx_q), .ny_i(ny_q), .den_i(den_q), .tag_i(f_q),
    .valid_o(v9), .qx_o(qx), .qy_o(qy), .tag_o(t9)
  );

  // stage E: saturation and result beat
  logic          done_q;
  logic [QW:0]   cx;
  logic [QW:0]   cy;
  logic [QW-1:0] fx_q;
  logic [QW-1:0] fy_q;
  logic          tc_q;
  logic          sat_q;

  assign cx = clip(qx, t9.bigx, t9.sx);
  assign cy = clip(qy, t9.bigy, t9.sy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v9;
    end
  end

  always_ff @(posedge clk_i) begin
    fx_q  <= t9.tc ? '0 : cx[QW-1:0];
    fy_q  <= t9.tc ? '0 : cy[QW-1:0];
    tc_q  <= t9.tc;
    sat_q <= !t9.tc && (cx[QW] || cy[QW]);
  end

  assign done_o      = done_q;
  assign force_x_o   = fx_q;
  assign force_y_o   = fy_q;
  assign too_close_o = tc_q;
  assign saturated_o = sat_q;

  `PGF_ASSERT_NOW(a_close_zero, clk_i, rst_ni, done_o && too_close_o, force_x_o == '0 && force_y_o == '0)
  `PGF_ASSERT_NOW(a_close_nosat, clk_i, rst_ni, done_o && too_close_o, !saturated_o)
  `PGF_ASSERT_NEXT(a_cfg_write, clk_i, rst_ni, cfg_valid_i && cfg_ready_o, gravity_q == $past(cfg_data_i))

endmodule

### bench/tb_top.sv
// Self-checking testbench for pairwise_gravity_force: random and directed body pairs.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CoordWidth    = pgf_pkg::CoordWidth;
  localparam int unsigned MassW         = pgf_pkg::MassW;
  localparam int unsigned GravW         = pgf_pkg::GravW;
  localparam int unsigned ForceW        = pgf_pkg::ForceW;
  localparam int unsigned TooCloseExp   = pgf_pkg::TooCloseExp;
  localparam logic [GravW-1:0] GravReset = pgf_pkg::GravReset;

  localparam int unsigned LatencyCycles = 110;
  localparam int unsigned StallLimit    = 5000;

  typedef struct packed {
    logic signed [CoordWidth-1:0] self_x;
    logic signed [CoordWidth-1:0] self_y;
    logic [MassW-1:0]             self_mass;
    logic signed [CoordWidth-1:0] other_x;
    logic signed [CoordWidth-1:0] other_y;
    logic [MassW-1:0]             other_mass;
  } body_pair_t;

  typedef struct packed {
    logic signed [ForceW-1:0] force_x;
    logic signed [ForceW-1:0] force_y;
    logic                     too_close;
    logic                     saturated;
  } force_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [CoordWidth-1:0] self_x_i = '0, self_y_i = '0;
  logic signed [CoordWidth-1:0] other_x_i = '0, other_y_i = '0;
  logic [MassW-1:0] self_mass_i = '0, other_mass_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [GravW-1:0] cfg_data_i = '0;
  logic done_o;
  logic signed [ForceW-1:0] force_x_o, force_y_o;
  logic too_close_o, saturated_o;

  body_pair_t pending_pairs[$];
  force_t     expected_forces[$];
  body_pair_t driven_pair = '0;
  logic [GravW-1:0] grav_const = GravReset;
  int unsigned gap_left = 0;
  bit          no_idle = 1'b0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  pairwise_gravity_force dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic force_t predict_force(input body_pair_t p, input logic [GravW-1:0] g);
    logic signed [CoordWidth+1:0] delta[2];
    logic [191:0] mag[2];
    logic [191:0] d2, r, t, num, den, q;
    logic [191:0] lim;
    logic [ForceW-1:0] comp[2];
    force_t f;
    delta[0] = $signed({{2{p.other_x[CoordWidth-1]}}, p.other_x})
             - $signed({{2{p.self_x[CoordWidth-1]}}, p.self_x});
    delta[1] = $signed({{2{p.other_y[CoordWidth-1]}}, p.other_y})
             - $signed({{2{p.self_y[CoordWidth-1]}}, p.self_y});
    f = '0;
    for (int i = 0; i < 2; i++)
      mag[i] = delta[i] < 0 ? 192'(-delta[i]) : 192'(delta[i]);
    d2 = mag[0] * mag[0] + mag[1] * mag[1];
    if (d2 < (192'(1) << TooCloseExp)) begin
      f.too_close = 1'b1;
      return f;
    end
    r = '0;
    for (int b = CoordWidth + 1; b >= 0; b--) begin
      t = r | (192'(1) << b);
      if (t * t <= d2) r = t;
    end
    num = 192'(g) * 192'(p.self_mass) * 192'(p.other_mass);
    den = d2 * r * 192'd16;
    lim = 192'(1) << (ForceW - 1);
    for (int i = 0; i < 2; i++) begin
      q = (num * mag[i]) / den;
      if (delta[i] < 0) begin
        if (q > lim) begin
          q = lim;
          f.saturated = 1'b1;
        end
        comp[i] = ForceW'(-q);
      end else begin
        if (q > lim - 1) begin
          q = lim - 1;
          f.saturated = 1'b1;
        end
        comp[i] = ForceW'(q);
      end
    end
    f.force_x = comp[0];
    f.force_y = comp[1];
    return f;
  endfunction

  function automatic logic [CoordWidth-1:0] rand_coord(input logic [CoordWidth-1:0] base);
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return base + CoordWidth'($urandom_range(0, 8192)) - CoordWidth'(4096);
      2: return base + CoordWidth'($urandom_range(0, 1 << 20)) - CoordWidth'(1 << 19);
      default: return $urandom_range(0, 1) ? {1'b0, {(CoordWidth-1){1'b1}}}
                                            : {1'b1, {(CoordWidth-1){1'b0}}};
    endcase
  endfunction

  function automatic logic [MassW-1:0] rand_mass();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 1 << 16);
      default: return $urandom();
    endcase
  endfunction

  function automatic body_pair_t rand_pair();
    body_pair_t p;
    p.self_x = $urandom();
    p.self_y = $urandom();
    p.other_x = rand_coord(p.self_x);
    p.other_y = rand_coord(p.self_y);
    p.self_mass = rand_mass();
    p.other_mass = rand_mass();
    return p;
  endfunction

  function automatic void add_pair(input logic [31:0] sx, sy, sm, ox, oy, om);
    body_pair_t p;
    p.self_x = sx; p.self_y = sy; p.self_mass = sm;
    p.other_x = ox; p.other_y = oy; p.other_mass = om;
    pending_pairs.push_back(p);
  endfunction

  // pair driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o)
        expected_forces.push_back(predict_force(driven_pair, grav_const));
      if (!(start_i && busy_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          if (!no_idle && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 15) - 1;
            start_i <= 1'b0;
          end else begin
            driven_pair = pending_pairs.pop_front();
            self_x_i <= driven_pair.self_x;
            self_y_i <= driven_pair.self_y;
            self_mass_i <= driven_pair.self_mass;
            other_x_i <= driven_pair.other_x;
            other_y_i <= driven_pair.other_y;
            other_mass_i <= driven_pair.other_mass;
            start_i <= 1'b1;
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and watchdog
  always @(posedge clk_i) begin
    force_t exp_f;
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("[pairwise_gravity_force] ERROR");
        $finish;
      end
      if (done_o) begin
        if (expected_forces.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat");
        end else begin
          exp_f = expected_forces.pop_front();
          if (force_x_o !== exp_f.force_x || force_y_o !== exp_f.force_y ||
              too_close_o !== exp_f.too_close || saturated_o !== exp_f.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp fx=%0d fy=%0d tc=%b sat=%b got fx=%0d fy=%0d tc=%b sat=%b",
                       exp_f.force_x, exp_f.force_y, exp_f.too_close, exp_f.saturated,
                       force_x_o, force_y_o, too_close_o, saturated_o);
          end
        end
      end
    end
  end

  task automatic drain();
    do @(posedge clk_i);
    while (pending_pairs.size() != 0 || start_i || expected_forces.size() != 0);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  task automatic write_grav(input logic [GravW-1:0] value);
    @(posedge clk_i);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    grav_const = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_pairs(input int unsigned n);
    for (int i = 0; i < n; i++) pending_pairs.push_back(rand_pair());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_pair(0, 0, 32'h100, 0, 0, 32'h100);
    add_pair(0, 0, 32'h100, 4095, 0, 32'h100);
    add_pair(0, 0, 32'h100, 4096, 0, 32'h100);
    add_pair(0, 0, 32'h100, 0, -4096, 32'h100);
    add_pair(100, 200, 32'h100, 100 + 2896, 200 + 2896, 32'h100);
    add_pair(32'h8000_0000, 32'h8000_0000, '1, 32'h7fff_ffff, 32'h7fff_ffff, '1);
    add_pair(32'h7fff_ffff, 32'h7fff_ffff, '1, 32'h8000_0000, 32'h8000_0000, '1);
    add_pair(0, 0, '1, 4096, 0, '1);
    add_pair(0, 0, '1, -4096, -4096, '1);
    add_pair(0, 0, 0, 40960, 12345, '1);
    add_pair(5000, -5000, '1, -9000, 7000, 0);
    add_pair(32'h1234_5678, -32'h0876_5432, 32'h0010_0000, 32'h0234_5678, 32'h0876_5432,
             32'h0020_0000);
    drain();

    write_grav('0);
    add_pair(0, 0, '1, 4096, 4096, '1);
    add_pair(0, 0, 32'h100, 8192, 0, 32'h100);
    random_pairs(10);
    drain();

    write_grav('1);
    add_pair(0, 0, '1, 4096, 0, '1);
    add_pair(0, 0, 32'h100, -8192, 4096, 32'h100);
    add_pair(32'h8000_0000, 0, 1, 32'h7fff_ffff, 0, 1);
    random_pairs(40);
    drain();

    write_grav($urandom());
    random_pairs(200);
    drain();

    write_grav(GravReset);
    random_pairs(150);
    drain();

    no_idle = 1'b1;
    random_pairs(150);
    drain();

    if (expected_forces.size() != 0) mismatches++;
    if (mismatches == 0)
      $display("[pairwise_gravity_force] OK");
    else
      $display("[pairwise_gravity_force] ERROR");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/pgf_pkg.sv
design/pgf_mul.sv
design/pgf_sqrt.sv
design/pgf_div.sv
design/pairwise_gravity_force.sv
bench/tb_top.sv
